/* hdl/bitmap_block_allocator_unit_defines.svh */
// assertion macros for the bitmap block allocator
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bba assertion failed");
// condition must never be true out of reset
`define BBA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bba forbidden condition seen");
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop)
`define BBA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/bba_pkg.sv */
// shared types and constants of the bitmap block allocator
// no dependencies
package bba_pkg;

	localparam int BLK_W   = 12;
	localparam int INODE_W = 12;
	localparam int DISK_W  = 13;
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// result status codes
	localparam logic [1:0] ST_DONE        = 2'd0;
	localparam logic [1:0] ST_NOT_MOUNTED = 2'd1;
	localparam logic [1:0] ST_NO_SPACE    = 2'd2;
	localparam logic [1:0] ST_IGNORED     = 2'd3;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_MOUNTED = 2'd0;
	localparam logic [1:0] REG_INODE   = 2'd1;
	localparam logic [1:0] REG_DISK    = 2'd2;

	localparam logic [DISK_W-1:0] DISK_RESET = 13'd4096;

	typedef struct packed {
		logic               mounted;
		logic [INODE_W-1:0] inode_block_count;
		logic [DISK_W-1:0]  disk_block_count;
	} bba_cfg_t;

	// search window of one map word
	typedef struct packed {
		logic             first;
		logic             last;
		logic [BIT_W-1:0] lo_bit;
		logic [BIT_W-1:0] hi_bit;
	} bba_win_t;

	// first free bit found in a word
	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} bba_hit_t;

endpackage

/* hdl/bba_if.sv */
// request and response channel interfaces of the bitmap block allocator
// depends on bba_pkg
interface bba_req_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [BLK_W-1:0] target_blk;

	modport source (output valid, output mode, output target_blk, input ready);
	modport sink (input valid, input mode, input target_blk, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [BLK_W-1:0] allocated_block;

	modport source (output valid, output status, output allocated_block, input ready);
	modport sink (input valid, input status, input allocated_block, output ready);
endinterface

/* hdl/bba_cfg_regs.sv */
// apb configuration registers: mounted, inode block count, disk block count
// depends on bba_pkg
module bba_cfg_regs import bba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output bba_cfg_t           cfg
);

	bba_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mounted           <= 1'b0;
			cfg_q.inode_block_count <= '0;
			cfg_q.disk_block_count  <= DISK_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MOUNTED: cfg_q.mounted           <= pwdata[0];
				REG_INODE:   cfg_q.inode_block_count <= pwdata[INODE_W-1:0];
				REG_DISK:    cfg_q.disk_block_count  <= pwdata[DISK_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_MOUNTED: prdata = PDATA_W'(cfg_q.mounted);
			REG_INODE:   prdata = PDATA_W'(cfg_q.inode_block_count);
			REG_DISK:    prdata = PDATA_W'(cfg_q.disk_block_count);
			default:     prdata = '0;
		endcase
	end

endmodule

/* hdl/bba_map_ram.sv */
// used-map memory: one write port, one read port, registered read data
// depends on bba_pkg
module bba_map_ram import bba_pkg::*; #(
	parameter int WORDS = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [WORDS];

	// storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/bba_word_scan.sv */
// finds the lowest free block of one map word inside the search window
// depends on bba_pkg
module bba_word_scan import bba_pkg::*; (
	input  logic [WORD_W-1:0] word,
	input  bba_win_t          win,
	output bba_hit_t          res
);

	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] avail;
	logic [WORD_W-1:0] lowest;

	// window masks on the first and last word of the range
	assign lo_mask = win.first ? ({WORD_W{1'b1}} << win.lo_bit) : {WORD_W{1'b1}};
	assign hi_mask = win.last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - win.hi_bit))
		: {WORD_W{1'b1}};
	assign avail  = ~word & lo_mask & hi_mask;
	// isolate the lowest set bit
	assign lowest = avail & (~avail + WORD_W'(1));

	// one-hot to binary
	always_comb begin
		res.hit = |avail;
		res.pos = '0;
		for (int k = 0; k < WORD_W; k++) begin
			for (int j = 0; j < BIT_W; j++) begin
				if (lowest[k] && k[j]) begin
					res.pos[j] = 1'b1;
				end
			end
		end
	end

endmodule

/* hdl/bitmap_block_allocator_unit.sv */
// bitmap first-fit block allocator, top level: control sequencer
// depends on bba_pkg, bba_if, bba_cfg_regs, bba_map_ram, bba_word_scan
//
//  channel  | role   | payload
//  ---------+--------+-------------------------------------
//  req      | sink   | mode, target_blk
//  rsp      | source | status, allocated_block
//  apb      | slave  | mounted, inode_block_count, disk_block_count
//
// allocate: map words are scanned one 32-bit word per cycle (set by the single
//   read port of the map memory) until a free block or the last word; free: the
//   word is read and written back; refused or empty range: no map access
// after reset a clearing pass writes ceil(MAX_BLOCKS/32) words, req not ready
// one request in flight; the next is taken while a response waits in rsp
`include "bitmap_block_allocator_unit_defines.svh"
module bitmap_block_allocator_unit import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	bba_req_if.sink            req,
	bba_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = ($clog2(MAX_BLOCKS) + 1 > DISK_W) ? $clog2(MAX_BLOCKS) + 1
		: DISK_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FREE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	bba_cfg_t          cfg;
	logic [2:0]        state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     rd_addr_q;
	logic              issue_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     chk_addr_s1;
	logic [BIT_W-1:0]  free_bit_q;
	logic [1:0]        res_status_q;
	logic [BLK_W-1:0]  res_blk_q;
	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [BLK_W-1:0]  rsp_blk_q;

	logic [CW-1:0]     end_blk;
	logic [CW-1:0]     start_blk;
	logic [CW-1:0]     last_blk;
	logic [AW-1:0]     first_word;
	logic [AW-1:0]     last_word;
	logic [AW-1:0]     free_word;
	logic              free_ok;
	logic              accept;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] rdata;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	bba_win_t          win;
	bba_hit_t          hit;
	logic              scan_hit;
	logic              rsp_load;

	bba_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bba_map_ram #(.WORDS(WORDS), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	bba_word_scan u_scan (
		.word (rdata),
		.win  (win),
		.res  (hit)
	);

	// search range from configuration; user must keep it stable while a request is in flight, block does not enforce
	assign end_blk    = (CW'(cfg.disk_block_count) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
		: CW'(cfg.disk_block_count);
	assign start_blk  = CW'(cfg.inode_block_count) + CW'(1);
	assign last_blk   = end_blk - CW'(1);
	assign first_word = AW'(start_blk >> BIT_W);
	assign last_word  = AW'(last_blk >> BIT_W);
	assign free_word  = AW'(CW'(req.target_blk) >> BIT_W);
	assign free_ok    = (req.target_blk != '0) && (CW'(req.target_blk) < end_blk);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// window of the word now on the read data
	assign win.first  = (chk_addr_s1 == first_word);
	assign win.last   = (chk_addr_s1 == last_word);
	assign win.lo_bit = start_blk[BIT_W-1:0];
	assign win.hi_bit = last_blk[BIT_W-1:0];
	assign scan_hit   = (state_q == S_SCAN) && rd_valid_s1 && hit.hit;

	// read port: free lookup on accept, otherwise scan address
	assign re = (accept && cfg.mounted && (req.mode == MODE_FREE) && free_ok)
		|| ((state_q == S_SCAN) && issue_q && !scan_hit);
	assign raddr = (state_q == S_SCAN) ? rd_addr_q : free_word;

	// write port: clearing pass, allocate mark, free clear
	always_comb begin
		we    = 1'b0;
		waddr = chk_addr_s1;
		wdata = rdata;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
			end
			S_SCAN: begin
				we    = scan_hit;
				wdata = rdata | (WORD_W'(1) << hit.pos);
			end
			S_FREE: begin
				we    = rd_valid_s1;
				wdata = rdata & ~(WORD_W'(1) << free_bit_q);
			end
			default: ;
		endcase
	end

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			chk_addr_s1 <= raddr;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			issue_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (!cfg.mounted) begin
							state_q <= S_DONE;
						end else if (req.mode == MODE_ALLOC) begin
							if (start_blk >= end_blk) begin
								state_q <= S_DONE;
							end else begin
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else if (free_ok) begin
							state_q <= S_FREE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (re && (rd_addr_q == last_word)) begin
						issue_q <= 1'b0;
					end
					if (scan_hit || (rd_valid_s1 && win.last)) begin
						issue_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_FREE: begin
					if (rd_valid_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request result and scan address
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q    <= first_word;
			free_bit_q   <= req.target_blk[BIT_W-1:0];
			res_blk_q    <= '0;
			if (!cfg.mounted) begin
				res_status_q <= ST_NOT_MOUNTED;
			end else if (req.mode == MODE_ALLOC) begin
				res_status_q <= ST_NO_SPACE;
			end else if (free_ok) begin
				res_status_q <= ST_DONE;
			end else begin
				res_status_q <= ST_IGNORED;
			end
		end
		if ((state_q == S_SCAN) && re) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (scan_hit) begin
			res_status_q <= ST_DONE;
			res_blk_q    <= BLK_W'({chk_addr_s1, hit.pos});
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_blk_q    <= res_blk_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.allocated_block = rsp_blk_q;

	// checks
	`BBA_ASSERT(a_rd_in_work, clk, arst_n, rd_valid_s1 |-> (state_q == S_SCAN || state_q == S_FREE))
	`BBA_ASSERT(a_accept_moves, clk, arst_n, accept |=> (state_q != S_IDLE))
	`BBA_NEVER(a_no_write_idle, clk, arst_n, we && (state_q == S_IDLE || state_q == S_DONE))
	`BBA_ASSERT(a_blk_zero, clk, arst_n, (rsp.valid && rsp.status != ST_DONE) |-> (rsp.allocated_block == '0))

endmodule
